### rtl/core/gcds_pkg.sv
// Shared constants, tables and types of the great-circle distance core.
`default_nettype none

package gcds_pkg;

  // CORDIC datapath width (Q2.30 plus headroom) and iteration counts
  localparam int unsigned CW           = 34;
  localparam int unsigned CORDIC_STEPS = 30;
  localparam int unsigned SQRT_STEPS   = 31;
  localparam int unsigned SQRT_TOP     = 60;

  // CORDIC start value (inverse gain) and truncated arctangent table, Q2.30
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
  };

  // Angle constants, Q2.30
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam logic [31:0] PI_Q30      = 32'd3373259426;
  localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

  // Degrees (1e-7 units) to radians Q32: 2^32 + RAD_LO
  localparam logic [31:0] RAD_LO = 32'd3753943213;

  // Longitude/latitude difference wrap
  localparam logic signed [33:0] DEG_HALF  = 34'sd1800000000;
  localparam logic signed [33:0] DEG_TURN  = 34'sd3600000000;
  localparam logic signed [33:0] WRAP_UP   = 34'sd1800000000;
  localparam logic signed [33:0] WRAP_MID  = -34'sd1800000000;
  localparam logic signed [33:0] WRAP_DN   = -34'sd5400000000;

  // Distance scaling and km conversion (reciprocal of 1000, exact below 2^25)
  localparam logic [22:0] RADIUS_M      = 23'd6371000;
  localparam logic [25:0] DIV1000_MUL   = 26'd34359739;
  localparam int unsigned DIV1000_SH    = 35;
  localparam logic [17:0] PULSE_BASE    = 18'd1000;
  localparam logic [15:0] THR_RESET     = 16'd10;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_TARGET_LAT = 2'd0,
    CFG_TARGET_LON = 2'd1,
    CFG_ARRIVE_THR = 2'd2
  } cfg_idx_e;

  // CORDIC vector carried from cell to cell
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  // Square root remainder and partial root carried from cell to cell
  typedef struct packed {
    logic [60:0] v;
    logic [61:0] r;
  } sqrt_t;

endpackage

`default_nettype wire

### rtl/core/gcds_rot_cell.sv
// One rotation-mode CORDIC iteration, registered.
`default_nettype none

module gcds_rot_cell import gcds_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic    clk_i,
  input  logic    en_i,
  input  cordic_t vec_i,
  output cordic_t vec_o
);

  localparam logic signed [CW-1:0] ANGLE = $signed({{(CW-32){1'b0}}, ATAN_TAB[STEP]});

  logic signed [CW-1:0] x, y, z;
  cordic_t vec_d, vec_q;

  assign x = vec_i.x;
  assign y = vec_i.y;
  assign z = vec_i.z;

  // rotate toward zero residual angle
  always_comb begin
    if (z >= 0) begin
      vec_d.x = x - (y >>> STEP);
      vec_d.y = y + (x >>> STEP);
      vec_d.z = z - ANGLE;
    end else begin
      vec_d.x = x + (y >>> STEP);
      vec_d.y = y - (x >>> STEP);
      vec_d.z = z + ANGLE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

`default_nettype wire

### rtl/core/gcds_vec_cell.sv
// One vectoring-mode CORDIC iteration, registered.
`default_nettype none

module gcds_vec_cell import gcds_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic    clk_i,
  input  logic    en_i,
  input  cordic_t vec_i,
  output cordic_t vec_o
);

  localparam logic signed [CW-1:0] ANGLE = $signed({{(CW-32){1'b0}}, ATAN_TAB[STEP]});

  logic signed [CW-1:0] x, y, z;
  cordic_t vec_d, vec_q;

  assign x = vec_i.x;
  assign y = vec_i.y;
  assign z = vec_i.z;

  // drive y toward zero, accumulate angle
  always_comb begin
    if (y > 0) begin
      vec_d.x = x + (y >>> STEP);
      vec_d.y = y - (x >>> STEP);
      vec_d.z = z + ANGLE;
    end else begin
      vec_d.x = x - (y >>> STEP);
      vec_d.y = y + (x >>> STEP);
      vec_d.z = z - ANGLE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vec_q <= vec_d;
    end
  end

  assign vec_o = vec_q;

endmodule

`default_nettype wire

### rtl/core/gcds_sqrt_cell.sv
// One digit step of the restoring integer square root, registered.
`default_nettype none

module gcds_sqrt_cell import gcds_pkg::*; #(
  parameter int unsigned STEP = 0
) (
  input  logic  clk_i,
  input  logic  en_i,
  input  sqrt_t sq_i,
  output sqrt_t sq_o
);

  localparam logic [61:0] BIT = 62'(1) << (SQRT_TOP - 2 * STEP);

  logic [61:0] trial;
  sqrt_t sq_d, sq_q;

  // try subtracting root + bit from the remainder
  always_comb begin
    trial = sq_i.r + BIT;
    if ({1'b0, sq_i.v} >= trial) begin
      sq_d.v = sq_i.v - trial[60:0];
      sq_d.r = (sq_i.r >> 1) + BIT;
    end else begin
      sq_d.v = sq_i.v;
      sq_d.r = sq_i.r >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

`default_nettype wire

### rtl/core/great_circle_distance_speed_core.sv
// Throughput: one item per cycle unless stalled; up to 104 items in flight.
// Depth is set by the 30 rotation cells, 31 square root cells and 30
// vectoring cells plus 13 prep and finish stages; an output stall freezes it.
// Reset clears the valid chain and loads target 0/0 and threshold 10 m.
`default_nettype none

module great_circle_distance_speed_core import gcds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // fix input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [30:0] cur_lat, [62:31] cur_lon
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [24:0] distance_m, [42:25] pulse_us
  output logic        m_axis_tuser    // [0] arrive
);

  localparam int unsigned LAT = 104;

  // ---------------------------------------------------------------------------
  // helpers
  function automatic logic signed [31:0] wrap_fn(input logic signed [33:0] raw);
    logic signed [33:0] adj;
    logic signed [33:0] sum;
    if (raw < 0) adj = WRAP_UP;
    else if (raw >= DEG_TURN) adj = WRAP_DN;
    else adj = WRAP_MID;
    sum = raw + adj;
    return sum[31:0];
  endfunction

  function automatic logic [30:0] mag31_fn(input logic signed [30:0] v);
    logic signed [30:0] n;
    n = -v;
    return v[30] ? n : v;
  endfunction

  function automatic logic [31:0] angle_fn(input logic [30:0] m, input logic half);
    logic [65:0] acc;
    acc = ({35'd0, m} << 32) + (66'(m) * 66'(RAD_LO))
        + (half ? (66'd1 << 32) : (66'd1 << 31));
    return half ? acc[64:33] : acc[63:32];
  endfunction

  function automatic logic signed [33:0] qmul_fn(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [63:0] p;
    logic signed [64:0] acc;
    p = a * b;
    acc = 65'(p) + 65'sd536870912;
    return acc[63:30];
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  logic signed [30:0] tgt_lat_q;
  logic signed [31:0] tgt_lon_q;
  logic [15:0]        thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_lat_q <= '0;
      tgt_lon_q <= '0;
      thr_q     <= THR_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET_LAT: tgt_lat_q <= cfg_data_i[30:0];
        CFG_TARGET_LON: tgt_lon_q <= cfg_data_i;
        CFG_ARRIVE_THR: thr_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // chain advance and valid tracking
  logic           adv;
  logic [LAT-1:0] vld_q;

  assign adv           = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: raw differences, offset for wrapping
  logic signed [30:0] cur_lat;
  logic signed [31:0] cur_lon;
  logic signed [33:0] dlat_raw_q, dlon_raw_q;
  logic signed [30:0] lat1_q;

  assign cur_lat = s_axis_tdata[30:0];
  assign cur_lon = s_axis_tdata[62:31];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dlat_raw_q <= $signed({{3{tgt_lat_q[30]}}, tgt_lat_q})
                  - $signed({{3{cur_lat[30]}}, cur_lat}) + DEG_HALF;
      dlon_raw_q <= $signed({{2{tgt_lon_q[31]}}, tgt_lon_q})
                  - $signed({{2{cur_lon[31]}}, cur_lon}) + DEG_HALF;
      lat1_q     <= cur_lat;
    end
  end

  // stage 2: wrap differences, latitude magnitudes
  logic signed [31:0] dlat_q, dlon_q;
  logic [30:0]        mlat1_2q, mlat2_2q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dlat_q   <= wrap_fn(dlat_raw_q);
      dlon_q   <= wrap_fn(dlon_raw_q);
      mlat1_2q <= mag31_fn(lat1_q);
      mlat2_2q <= mag31_fn(tgt_lat_q);
    end
  end

  // stage 3: difference magnitudes
  logic [30:0] mdlat_q, mdlon_q, mlat1_3q, mlat2_3q;
  logic signed [31:0] ndlat, ndlon;

  assign ndlat = -dlat_q;
  assign ndlon = -dlon_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mdlat_q  <= dlat_q[31] ? ndlat[30:0] : dlat_q[30:0];
      mdlon_q  <= dlon_q[31] ? ndlon[30:0] : dlon_q[30:0];
      mlat1_3q <= mlat1_2q;
      mlat2_3q <= mlat2_2q;
    end
  end

  // stage 4: convert to Q2.30 radians (half angles for differences)
  logic [31:0] ang_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ang_q[0] <= angle_fn(mdlat_q, 1'b1);
      ang_q[1] <= angle_fn(mdlon_q, 1'b1);
      ang_q[2] <= angle_fn(mlat1_3q, 1'b0);
      ang_q[3] <= angle_fn(mlat2_3q, 1'b0);
    end
  end

  // stage 5: fold latitudes past pi/2, load CORDIC start vectors
  cordic_t    rot_q [4];
  logic [1:0] neg_q [CORDIC_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        rot_q[l].x <= CORDIC_GAIN;
        rot_q[l].y <= '0;
        if (l >= 2 && ang_q[l] > HALF_PI_Q30) begin
          rot_q[l].z <= $signed({2'b00, PI_Q30 - ang_q[l]});
        end else begin
          rot_q[l].z <= $signed({2'b00, ang_q[l]});
        end
      end
      neg_q[0] <= {ang_q[3] > HALF_PI_Q30, ang_q[2] > HALF_PI_Q30};
      for (int k = 1; k <= CORDIC_STEPS; k++) begin
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  // rotation cells: four lanes (dlat/2, dlon/2, lat1, lat2)
  cordic_t rot_w [CORDIC_STEPS+1][4];

  for (genvar l = 0; l < 4; l++) begin : g_rot_lane
    assign rot_w[0][l] = rot_q[l];
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_rot_step
      gcds_rot_cell #(.STEP(k)) u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .vec_i (rot_w[k][l]),
        .vec_o (rot_w[k+1][l])
      );
    end
  end

  // stage 36: apply cosine sign, pick sines
  logic signed [31:0] cos1_q, cos2_q, sin_lat_q, sin_lon_q;
  logic signed [31:0] c1, c2;

  assign c1 = rot_w[CORDIC_STEPS][2].x[31:0];
  assign c2 = rot_w[CORDIC_STEPS][3].x[31:0];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cos1_q    <= neg_q[CORDIC_STEPS][0] ? -c1 : c1;
      cos2_q    <= neg_q[CORDIC_STEPS][1] ? -c2 : c2;
      sin_lat_q <= rot_w[CORDIC_STEPS][0].y[31:0];
      sin_lon_q <= rot_w[CORDIC_STEPS][1].y[31:0];
    end
  end

  // stage 37: squares and cosine product
  logic signed [33:0] sq_lat_q, sq_lon_q, cc_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_lat_q <= qmul_fn(sin_lat_q, sin_lat_q);
      sq_lon_q <= qmul_fn(sin_lon_q, sin_lon_q);
      cc_q     <= qmul_fn(cos1_q, cos2_q);
    end
  end

  // stage 38: weight longitude term
  logic signed [33:0] sq_lat_38q, lon_term_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_lat_38q <= sq_lat_q;
      lon_term_q <= qmul_fn(cc_q[31:0], sq_lon_q[31:0]);
    end
  end

  // stage 39: haversine a, clamped to [0, 1]
  logic signed [34:0] a_sum;
  logic [30:0]        a_q;

  assign a_sum = 35'(sq_lat_38q) + 35'(lon_term_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (a_sum < 0) a_q <= '0;
      else if (a_sum > $signed({4'd0, Q30_ONE})) a_q <= Q30_ONE;
      else a_q <= a_sum[30:0];
    end
  end

  // stage 40: square root operands a and 1 - a, scaled by 2^30
  sqrt_t sqin_q [2];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqin_q[0].v <= {a_q, 30'd0};
      sqin_q[0].r <= '0;
      sqin_q[1].v <= {Q30_ONE - a_q, 30'd0};
      sqin_q[1].r <= '0;
    end
  end

  // square root cells: two lanes
  sqrt_t sq_w [SQRT_STEPS+1][2];

  for (genvar l = 0; l < 2; l++) begin : g_sqrt_lane
    assign sq_w[0][l] = sqin_q[l];
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt_step
      gcds_sqrt_cell #(.STEP(k)) u_cell (
        .clk_i (clk_i),
        .en_i  (adv),
        .sq_i  (sq_w[k][l]),
        .sq_o  (sq_w[k+1][l])
      );
    end
  end

  // vectoring cells: atan2(sqrt(a), sqrt(1 - a))
  cordic_t vec_w [CORDIC_STEPS+1];

  assign vec_w[0].x = $signed({3'd0, sq_w[SQRT_STEPS][1].r[30:0]});
  assign vec_w[0].y = $signed({3'd0, sq_w[SQRT_STEPS][0].r[30:0]});
  assign vec_w[0].z = '0;

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_vec_step
    gcds_vec_cell #(.STEP(k)) u_cell (
      .clk_i (clk_i),
      .en_i  (adv),
      .vec_i (vec_w[k]),
      .vec_o (vec_w[k+1])
    );
  end

  // stage 102: distance in meters, R * 2z
  logic [30:0] z_pos;
  logic [53:0] dist_prod;
  logic [24:0] dist_q;

  assign z_pos     = vec_w[CORDIC_STEPS].z[CW-1] ? '0 : vec_w[CORDIC_STEPS].z[30:0];
  assign dist_prod = 54'(z_pos) * 54'(RADIUS_M) + (54'd1 << 28);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_q <= dist_prod[53:29];
    end
  end

  // stage 103: whole kilometers by reciprocal, threshold compare
  logic [50:0] km_prod;
  logic [15:0] km_q;
  logic [24:0] dist_103q;
  logic        far_q;

  assign km_prod = 51'(dist_q) * 51'(DIV1000_MUL);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      km_q      <= km_prod[50:DIV1000_SH];
      dist_103q <= dist_q;
      far_q     <= dist_q > 25'(thr_q);
    end
  end

  // stage 104: output register
  logic [24:0] dist_o_q;
  logic [17:0] pulse_q;
  logic        arrive_q;
  logic [17:0] km18;

  assign km18 = 18'(km_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dist_o_q <= dist_103q;
      pulse_q  <= far_q ? (km18 << 3) + (km18 << 1) + PULSE_BASE : '0;
      arrive_q <= !far_q;
    end
  end

  assign m_axis_tdata = {5'd0, pulse_q, dist_o_q};
  assign m_axis_tuser = arrive_q;

`ifndef SYNTH
  // arrived results carry no pulse
  a_arrive_no_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> pulse_q == '0)
    else $error("pulse nonzero on arrive");

  // moving results carry at least the base pulse
  a_move_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> pulse_q >= PULSE_BASE)
    else $error("pulse below base while moving");

  // arrive flag agrees with distance and threshold
  a_arrive_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser == (dist_o_q <= 25'(thr_q)))
    else $error("arrive flag disagrees with threshold");

  // chain holds its items while stalled
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |=> $stable(vld_q))
    else $error("valid chain moved during stall");
`endif

endmodule

`default_nettype wire
